FILE: rtl/length_framed_packet_receiver_core_assert.svh
// Assertion macros shared by the packet receiver checkers.
`ifndef LENGTH_FRAMED_PACKET_RECEIVER_CORE_ASSERT_SVH
`define LENGTH_FRAMED_PACKET_RECEIVER_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define LFPR_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("lfpr check failed");

// Next-cycle implication, sampled on clk_i, off during reset.
`define LFPR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("lfpr check failed");

`endif

FILE: rtl/lfpr_pkg.sv
// Shared constants and types of the length framed packet receiver.
`default_nettype none

package lfpr_pkg;

  // Frame store geometry and length limits
  localparam int unsigned MaxFrame  = 64;
  localparam int unsigned MinFrame  = 5;
  localparam int unsigned StoreAw   = $clog2(MaxFrame);
  localparam int unsigned LenW      = StoreAw + 1;

  // Register reset values
  localparam logic [7:0] StartByteRst = 8'h02;
  localparam logic [7:0] EndByteRst   = 8'h03;

  // Register indexes (byte address bit 2)
  localparam logic RegStart = 1'b0;
  localparam logic RegEnd   = 1'b1;

  // Receive / emit sequencer
  typedef enum logic [1:0] {
    ST_RECV = 2'b01,
    ST_EMIT = 2'b10
  } state_e;

endpackage

`default_nettype wire

FILE: rtl/length_framed_packet_receiver_core.sv
// Top level of the length framed packet receiver with XOR checksum.
//
//   channel  | handshake               | payload
//   ---------+-------------------------+---------------------------------------------
//   rx       | rx_valid_i / rx_ready_o | rx_byte_i
//   out      | out_valid_o/out_ready_i | packet_byte_o byte_position_o frame_length_o
//            |                         | last_byte_o
//   apb      | psel penable pwrite     | paddr pwdata prdata (pready tied high)
//
// Receive: one word per cycle while rx_ready_o is high, each stored byte written to the frame RAM.
// A good frame of N bytes is then replayed from the RAM one word at a time (RAM read,
// then output register load, before the next read); rx_ready_o is low meanwhile.
// The frame RAM needs no clearing after reset; only written entries are read.
// Out stalls hold the replay; a stalled output word never blocks rx once the
// last word of the frame sits in the output register.
`default_nettype none

module length_framed_packet_receiver_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // config port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  // received bytes
  input  wire logic        rx_valid_i,
  output logic             rx_ready_o,
  input  wire logic [7:0]  rx_byte_i,
  // validated frame words
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic      [7:0]  packet_byte_o,
  output logic      [5:0]  byte_position_o,
  output logic      [6:0]  frame_length_o,
  output logic             last_byte_o
);

  localparam int unsigned Aw = lfpr_pkg::StoreAw;
  localparam int unsigned Lw = lfpr_pkg::LenW;

  lfpr_pkg::state_e state_q, state_d;

  logic [7:0]    start_q, end_q;
  logic [Lw-1:0] fill_q, fill_d;
  logic [Lw-1:0] decl_q, decl_d;
  logic [7:0]    xor_q, xor_d;
  logic [7:0]    prev_q, prev_d;
  logic [Aw-1:0] emit_idx_q, emit_idx_d;
  logic [Aw-1:0] rd_pos_q;
  logic          pend_q, out_valid_q, out_valid_d;
  logic [7:0]    pkt_q;
  logic [Aw-1:0] pos_q;
  logic [Lw-1:0] len_q;
  logic          last_q;

  logic          rx_acc, cfg_wr, ram_we, issue, load_last;
  logic [Lw-1:0] fill_inc;
  logic [7:0]    ram_rdata;

  // Config registers
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = {24'd0, (paddr[2] == lfpr_pkg::RegEnd) ? end_q : start_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= lfpr_pkg::StartByteRst;
      end_q   <= lfpr_pkg::EndByteRst;
    end else if (cfg_wr) begin
      if (paddr[2] == lfpr_pkg::RegStart) begin
        start_q <= pwdata[7:0];
      end else begin
        end_q <= pwdata[7:0];
      end
    end
  end

  assign rx_ready_o = (state_q == lfpr_pkg::ST_RECV);
  assign rx_acc     = rx_valid_i && rx_ready_o;
  assign fill_inc   = fill_q + Lw'(1);

  // Receive path: store, length check, end/checksum check
  always_comb begin
    fill_d  = fill_q;
    decl_d  = decl_q;
    xor_d   = xor_q;
    prev_d  = prev_q;
    state_d = state_q;
    ram_we  = 1'b0;
    emit_idx_d = emit_idx_q;
    if (rx_acc) begin
      if (fill_q == '0 && rx_byte_i != start_q) begin
        // idle noise, dropped
      end else if (fill_q[Lw-1]) begin
        // store full: drop word, back to idle
        fill_d = '0;
        decl_d = '0;
        xor_d  = '0;
      end else begin
        ram_we = 1'b1;
        fill_d = fill_inc;
        xor_d  = xor_q ^ rx_byte_i;
        prev_d = rx_byte_i;
        if (fill_q == Lw'(1)) begin
          if (rx_byte_i inside {[lfpr_pkg::MinFrame:lfpr_pkg::MaxFrame]}) begin
            decl_d = rx_byte_i[Lw-1:0];
          end else begin
            fill_d = '0;
            decl_d = '0;
            xor_d  = '0;
          end
        end else if (fill_q != '0 && fill_inc == decl_q) begin
          // frame end by length; decl_q is kept for the replay
          fill_d = '0;
          xor_d  = '0;
          if (prev_q == end_q && rx_byte_i == xor_q) begin
            state_d    = lfpr_pkg::ST_EMIT;
            emit_idx_d = '0;
          end else begin
            decl_d = '0;
          end
        end
      end
    end
    // replay: read issue, then load into the output register
    if (issue) begin
      emit_idx_d = emit_idx_q + Aw'(1);
    end
    if (pend_q && load_last) begin
      state_d = lfpr_pkg::ST_RECV;
    end
  end

  // Replay control: one RAM read outstanding, issued only when the
  // output register is free at the load edge
  assign issue = (state_q == lfpr_pkg::ST_EMIT) && !pend_q &&
                 (!out_valid_q || out_ready_i);
  assign load_last = ({1'b0, rd_pos_q} + Lw'(1)) == decl_q;
  assign out_valid_d = pend_q ? 1'b1 : (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lfpr_pkg::ST_RECV;
      fill_q      <= '0;
      decl_q      <= '0;
      xor_q       <= '0;
      prev_q      <= '0;
      emit_idx_q  <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      decl_q      <= decl_d;
      xor_q       <= xor_d;
      prev_q      <= prev_d;
      emit_idx_q  <= emit_idx_d;
      pend_q      <= issue;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (issue) begin
      rd_pos_q <= emit_idx_q;
    end
    if (pend_q) begin
      pkt_q  <= ram_rdata;
      pos_q  <= rd_pos_q;
      len_q  <= decl_q;
      last_q <= load_last;
    end
  end

  // Frame store
  lfpr_ram #(
    .Width (8),
    .Depth (lfpr_pkg::MaxFrame)
  ) u_frame_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (fill_q[Aw-1:0]),
    .wdata_i (rx_byte_i),
    .re_i    (issue),
    .raddr_i (emit_idx_q),
    .rdata_o (ram_rdata)
  );

  assign out_valid_o     = out_valid_q;
  assign packet_byte_o   = pkt_q;
  assign byte_position_o = pos_q;
  assign frame_length_o  = len_q;
  assign last_byte_o     = last_q;

endmodule

`default_nettype wire

FILE: rtl/lfpr_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module lfpr_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: rtl/lfpr_checker.sv
// Port-level checker for the packet receiver, bound to the top level.
`default_nettype none
`include "length_framed_packet_receiver_core_assert.svh"

module lfpr_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        rx_ready_o,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire logic [7:0]  packet_byte_o,
  input wire logic [5:0]  byte_position_o,
  input wire logic [6:0]  frame_length_o,
  input wire logic        last_byte_o
);

  // stalled output word holds
  `LFPR_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(packet_byte_o) && $stable(byte_position_o))

  // frame length within the legal range
  `LFPR_ASSERT_NOW(a_len_range, out_valid_o, frame_length_o >= 7'd5 && frame_length_o <= 7'd64)

  // last mark exactly on the final position
  `LFPR_ASSERT_NOW(a_last_pos, out_valid_o, last_byte_o == (({1'b0, byte_position_o} + 7'd1) == frame_length_o))

  // receive stays closed while a replay is still running
  `LFPR_ASSERT_NEXT(a_rx_closed, out_valid_o && out_ready_i && !last_byte_o, !rx_ready_o)

endmodule

bind length_framed_packet_receiver_core lfpr_checker u_lfpr_checker (.*);

`default_nettype wire

FILE: bench/tb.sv
// Self-checking bench for the length framed packet receiver core.
`default_nettype none

module tb;

  // Where a typed row decides the outcome, or the frame predictor does
  typedef enum logic {
    WANT_NONE  = 1'b0,
    WANT_MODEL = 1'b1
  } want_e;

  typedef struct packed {
    logic [7:0] rx;
    want_e      want;
  } rx_row_t;

  typedef struct packed {
    logic [7:0] data;
    logic [5:0] pos;
    logic [6:0] len;
    logic       last;
  } frame_word_t;

  localparam int unsigned HoldCycles = 400;

  logic        clk_i;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        rx_valid_i;
  logic        rx_ready_o;
  logic [7:0]  rx_byte_i;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [7:0]  packet_byte_o;
  logic [5:0]  byte_position_o;
  logic [6:0]  frame_length_o;
  logic        last_byte_o;
  want_e       rx_want;

  // Predictor state: configuration and the frame being collected
  logic [7:0]  cfg_start;
  logic [7:0]  cfg_end;
  logic [7:0]  frame_mem [lfpr_pkg::MaxFrame];
  logic [6:0]  fill_cnt;
  logic [6:0]  decl_len;
  logic [7:0]  xor_acc;
  frame_word_t frame_words_due [$];

  int          mismatches = 0;
  int          frame_bytes_sent;
  int          idle_pct;
  int          stall_pct = 0;
  int          hold_req = 0;
  int          hold_seen = 0;
  int          hold_left = 0;

  // Directed words, checked by hand where the outcome is obvious
  rx_row_t directed_rows [25] = '{
    '{8'hFF, WANT_NONE},                        // idle noise
    '{8'h02, WANT_NONE}, '{8'h05, WANT_NONE},   // shortest good frame
    '{8'h00, WANT_NONE}, '{8'h03, WANT_NONE}, '{8'h04, WANT_MODEL},
    '{8'h02, WANT_NONE}, '{8'h04, WANT_NONE},   // length below minimum
    '{8'h02, WANT_NONE}, '{8'hFF, WANT_NONE},   // length above maximum
    '{8'h02, WANT_NONE}, '{8'h05, WANT_NONE},   // start byte as payload
    '{8'h02, WANT_NONE}, '{8'h03, WANT_NONE}, '{8'h06, WANT_MODEL},
    '{8'h02, WANT_NONE}, '{8'h05, WANT_NONE},   // wrong checksum
    '{8'hFF, WANT_NONE}, '{8'h03, WANT_NONE}, '{8'h00, WANT_NONE},
    '{8'h02, WANT_NONE}, '{8'h05, WANT_NONE},   // wrong end byte
    '{8'h00, WANT_NONE}, '{8'h04, WANT_NONE}, '{8'h03, WANT_NONE}
  };

  length_framed_packet_receiver_core dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .rx_valid_i      (rx_valid_i),
    .rx_ready_o      (rx_ready_o),
    .rx_byte_i       (rx_byte_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .packet_byte_o   (packet_byte_o),
    .byte_position_o (byte_position_o),
    .frame_length_o  (frame_length_o),
    .last_byte_o     (last_byte_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  // Drop the collected frame and wait for the next start byte
  function automatic void frame_clear();
    fill_cnt = '0;
    decl_len = '0;
    xor_acc  = '0;
  endfunction

  // Feed one received byte to the predictor; queue the frame once it checks out
  function automatic void frame_collect(input logic [7:0] b, input logic keep);
    logic [7:0]  xor_prev;
    logic [5:0]  end_idx;
    logic [5:0]  sum_idx;
    frame_word_t w;
    if (fill_cnt == 0 && b != cfg_start) return;
    if (fill_cnt >= lfpr_pkg::MaxFrame) begin
      frame_clear();
      return;
    end
    xor_prev = xor_acc;
    frame_mem[fill_cnt[5:0]] = b;
    fill_cnt = fill_cnt + 7'd1;
    xor_acc  = xor_acc ^ b;
    if (fill_cnt == 7'd2) begin
      if (b < lfpr_pkg::MinFrame || b > lfpr_pkg::MaxFrame) begin
        frame_clear();
        return;
      end
      decl_len = b[6:0];
    end
    if (fill_cnt < 7'd2 || fill_cnt != decl_len) return;
    end_idx = 6'(decl_len - 7'd2);
    sum_idx = 6'(decl_len - 7'd1);
    if (frame_mem[end_idx] == cfg_end && frame_mem[sum_idx] == xor_prev && keep) begin
      for (int k = 0; k < decl_len; k++) begin
        w.data = frame_mem[6'(k)];
        w.pos  = 6'(k);
        w.len  = decl_len;
        w.last = (k == decl_len - 1);
        frame_words_due.push_back(w);
      end
    end
    frame_clear();
  endfunction

  // Track accepted bytes and check every emitted word in order
  always @(posedge clk_i) begin
    frame_word_t got;
    frame_word_t exp_w;
    if (rst_ni) begin
      if (rx_valid_i && rx_ready_o) frame_collect(rx_byte_i, rx_want == WANT_MODEL);
      if (out_valid_o && out_ready_i) begin
        got = '{packet_byte_o, byte_position_o, frame_length_o, last_byte_o};
        if (frame_words_due.size() == 0) begin
          $display("%0t: unexpected word, expected none, got %h", $time, got);
          mismatches++;
        end else begin
          exp_w = frame_words_due.pop_front();
          if (got.data !== exp_w.data) begin
            $display("%0t: packet_byte expected %h got %h", $time, exp_w.data, got.data);
            mismatches++;
          end
          if (got.pos !== exp_w.pos) begin
            $display("%0t: byte_position expected %0d got %0d", $time, exp_w.pos, got.pos);
            mismatches++;
          end
          if (got.len !== exp_w.len) begin
            $display("%0t: frame_length expected %0d got %0d", $time, exp_w.len, got.len);
            mismatches++;
          end
          if (got.last !== exp_w.last) begin
            $display("%0t: last_byte expected %b got %b", $time, exp_w.last, got.last);
            mismatches++;
          end
        end
      end
    end
  end

  // Output back-pressure: random stalls, plus a long hold-off on request
  always @(negedge clk_i) begin
    if (hold_left != 0) begin
      out_ready_i <= 1'b0;
      hold_left   <= hold_left - 1;
    end else if (hold_seen != hold_req) begin
      out_ready_i <= 1'b0;
      hold_seen   <= hold_req;
      hold_left   <= HoldCycles;
    end else begin
      out_ready_i <= ($urandom_range(99) >= stall_pct);
    end
  end

  // One APB transfer; a read compares against the given value
  task automatic apb_xfer(input logic wr, input logic idx, input logic [7:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= {24'h0, val};
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (wr) begin
      if (idx == lfpr_pkg::RegStart) cfg_start = val;
      else cfg_end = val;
    end else if (prdata !== {24'h0, val}) begin
      $display("%0t: register %0d expected %h got %h", $time, idx, {24'h0, val}, prdata);
      mismatches++;
    end
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);
  endtask

  // Offer one word; entered and left just after a falling edge
  task automatic send_word(input logic [7:0] b, input want_e w);
    if ($urandom_range(99) < idle_pct) begin
      rx_valid_i <= 1'b0;
      do @(negedge clk_i); while ($urandom_range(99) < idle_pct);
    end
    rx_valid_i <= 1'b1;
    rx_byte_i  <= b;
    rx_want    <= w;
    do @(posedge clk_i); while (!rx_ready_o);
    @(negedge clk_i);
  endtask

  // One random frame: mostly good, some broken, some line noise
  task automatic send_frame();
    logic [7:0]  fr [$];
    logic [7:0]  sum;
    int unsigned pick;
    int unsigned flen;
    pick = $urandom_range(99);
    if (pick < 10) begin
      repeat ($urandom_range(3, 1)) send_word(8'($urandom_range(255)), WANT_MODEL);
      return;
    end
    fr.push_back(cfg_start);
    if (pick < 18) begin
      // length out of range
      if ($urandom_range(1)) fr.push_back(8'($urandom_range(lfpr_pkg::MinFrame - 1)));
      else fr.push_back(8'($urandom_range(255, lfpr_pkg::MaxFrame + 1)));
    end else begin
      if ($urandom_range(11) == 0)
        flen = $urandom_range(1) ? lfpr_pkg::MaxFrame : $urandom_range(lfpr_pkg::MaxFrame, 13);
      else
        flen = $urandom_range(12, lfpr_pkg::MinFrame);
      fr.push_back(8'(flen));
      repeat (flen - 4) fr.push_back(8'($urandom_range(255)));
      fr.push_back(cfg_end);
      if (pick < 26) fr[flen - 2] = fr[flen - 2] ^ 8'($urandom_range(255, 1));
      sum = '0;
      foreach (fr[i]) sum = sum ^ fr[i];
      if (pick >= 26 && pick < 34) sum = sum ^ 8'($urandom_range(255, 1));
      fr.push_back(sum);
    end
    foreach (fr[i]) send_word(fr[i], WANT_MODEL);
    frame_bytes_sent += fr.size();
  endtask

  // Let the block go idle: all words out, then a short quiet stretch
  task automatic settle();
    rx_valid_i <= 1'b0;
    while (frame_words_due.size() != 0) @(negedge clk_i);
    repeat (2 * lfpr_pkg::MaxFrame) @(negedge clk_i);
  endtask

  // Random frames under one register setting, one idling and stall mix and an optional output hold-off
  task automatic run_phase(input logic [7:0] sb, input logic [7:0] eb, input int idle_p,
                           input int stall_p, input int n_bytes, input logic hold);
    settle();
    apb_xfer(1'b1, lfpr_pkg::RegStart, sb);
    apb_xfer(1'b1, lfpr_pkg::RegEnd, eb);
    apb_xfer(1'b0, lfpr_pkg::RegStart, sb);
    apb_xfer(1'b0, lfpr_pkg::RegEnd, eb);
    idle_pct  = idle_p;
    stall_pct <= stall_p;
    if (hold) hold_req <= hold_req + 1;
    frame_bytes_sent = 0;
    while (frame_bytes_sent < n_bytes) send_frame();
    // finish any frame left open so the next setting starts from idle
    while (fill_cnt != 0) send_word(8'($urandom_range(255)), WANT_MODEL);
  endtask

  initial begin
    rst_ni     = 1'b0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    rx_valid_i = 1'b0;
    rx_byte_i  = '0;
    rx_want    = WANT_MODEL;
    idle_pct   = 0;
    cfg_start  = lfpr_pkg::StartByteRst;
    cfg_end    = lfpr_pkg::EndByteRst;
    frame_clear();
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset values, then the directed words back to back
    apb_xfer(1'b0, lfpr_pkg::RegStart, lfpr_pkg::StartByteRst);
    apb_xfer(1'b0, lfpr_pkg::RegEnd, lfpr_pkg::EndByteRst);
    foreach (directed_rows[i]) send_word(directed_rows[i].rx, directed_rows[i].want);
    frame_bytes_sent = 0;
    while (frame_bytes_sent < 54) send_frame();
    while (fill_cnt != 0) send_word(8'($urandom_range(255)), WANT_MODEL);

    run_phase(8'h00, 8'hFF, 60, 0, 54, 1'b0);
    run_phase(8'hFF, 8'h00, 0, 60, 54, 1'b0);
    run_phase(8'($urandom_range(255)), 8'($urandom_range(255)), 21, 21, 54, 1'b0);
    run_phase(lfpr_pkg::StartByteRst, lfpr_pkg::EndByteRst, 0, 0, 54, 1'b1);
    run_phase(8'($urandom_range(255)), 8'($urandom_range(255)), 21, 21, 54, 1'b0);

    settle();
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
